/* src/rkd_pkg.sv */
`default_nettype none

package rkd_pkg;

    // Working width of the modulus, the totient and both exponents.
    localparam int MOD_WIDTH   = 32;
    localparam int PRIME_WIDTH = 16;
    localparam int BLOCK_WIDTH = 16;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam int CNT_W       = $clog2(MOD_WIDTH);

    // Public exponent search: odd candidates from E_FIRST up to E_LAST.
    localparam int E_FIRST    = 3;
    localparam int E_STEP     = 2;
    localparam int E_LAST     = 255;
    localparam int BYTE_LIMIT = 256;

    // Register index, taken from paddr[2].
    localparam logic REG_PRIME_P = 1'b0;
    localparam logic REG_PRIME_Q = 1'b1;

    typedef logic [MOD_WIDTH-1:0] word_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        word_t product;
    } mul_rsp_t;

endpackage

`default_nettype wire

/* src/rsa_key_derive_and_modexp_unit.sv */
`default_nettype none

// Textbook RSA unit. Two 16-bit primes p and q are written over the APB port
// (p at address 0, q at address 4; reset values 251 and 257). On the first
// transaction after reset or after any register write the unit derives the
// modulus n = p*q, the totient (p-1)(q-1), the smallest odd public exponent
// e from 3 to 255 coprime to the totient (1 if there is none) and the private
// exponent d as the inverse of e modulo the totient. Every input transaction
// carries a command in tuser (0 encrypt with e, 1 decrypt with d) and a 16-bit
// block in tdata; the unit returns block^exponent mod n in tdata and, in tuser,
// a flag set when that result is below 256. One item is worked on at a time.
// All arithmetic runs on a shared bit-serial restoring divider and a bit-serial
// modular multiplier. An item with a derived key takes one base reduction and
// one modular product per exponent bit plus one per set bit; key derivation
// adds a Euclid run for every exponent candidate tried and an extended Euclid.
// A finished result is held in the output register until it is taken.
module rsa_key_derive_and_modexp_unit
    import rkd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input stream. tdata: block_value[15:0]. tuser: cmd[0].
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,
    input  wire logic              s_tuser,
    // Output stream. tdata: result_value[31:0]. tuser: fits_one_byte[0].
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tuser,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_KEY_MUL  = 5'd1;
    localparam logic [4:0] S_KEY_CHK  = 5'd2;
    localparam logic [4:0] S_GCD_LOAD = 5'd3;
    localparam logic [4:0] S_GCD_TEST = 5'd4;
    localparam logic [4:0] S_GCD_WT   = 5'd5;
    localparam logic [4:0] S_INV_DIV  = 5'd6;
    localparam logic [4:0] S_INV_TEST = 5'd7;
    localparam logic [4:0] S_INV_QM   = 5'd8;
    localparam logic [4:0] S_INV_MUL  = 5'd9;
    localparam logic [4:0] S_INV_C0   = 5'd10;
    localparam logic [4:0] S_EXP_INIT = 5'd11;
    localparam logic [4:0] S_EXP_BASE = 5'd12;
    localparam logic [4:0] S_EXP_STEP = 5'd13;
    localparam logic [4:0] S_EXP_MA   = 5'd14;
    localparam logic [4:0] S_EXP_MS   = 5'd15;
    localparam logic [4:0] S_OUT      = 5'd16;

    logic [4:0]             state_reg, state_next;
    logic [PRIME_WIDTH-1:0] p_reg, p_next;
    logic [PRIME_WIDTH-1:0] q_reg, q_next;
    logic                   key_ready_reg, key_ready_next;
    logic                   out_valid_reg, out_valid_next;
    logic [8:0]             cand_reg, cand_next;
    word_t mod_reg, mod_next;
    word_t tot_reg, tot_next;
    word_t e_reg, e_next;
    word_t d_reg, d_next;
    logic  cmd_reg, cmd_next;
    logic [BLOCK_WIDTH-1:0] blk_reg, blk_next;
    word_t ga_reg, ga_next;
    word_t gb_reg, gb_next;
    word_t c0_reg, c0_next;
    word_t c1_reg, c1_next;
    word_t x_reg, x_next;
    word_t quo_reg, quo_next;
    word_t rem_reg, rem_next;
    word_t sub_reg, sub_next;
    word_t acc_reg, acc_next;
    word_t sq_reg, sq_next;
    word_t ex_reg, ex_next;
    word_t res_reg, res_next;
    logic  fit_reg, fit_next;

    logic [2*PRIME_WIDTH-1:0] prod_pq;
    logic [2*PRIME_WIDTH-1:0] prod_tot;
    logic [PRIME_WIDTH-1:0]   pm1;
    logic [PRIME_WIDTH-1:0]   qm1;
    logic [MOD_WIDTH:0]       t_sum;
    word_t                    t_val;
    logic                     cfg_wr;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    rkd_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rkd_modmul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_PRIME_Q) ? {{(APB_DW-PRIME_WIDTH){1'b0}}, q_reg}
                                                : {{(APB_DW-PRIME_WIDTH){1'b0}}, p_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(res_reg);
    assign m_tuser  = fit_reg;

    // Factors below one saturate at zero.
    assign pm1      = (p_reg == '0) ? '0 : p_reg - 1'b1;
    assign qm1      = (q_reg == '0) ? '0 : q_reg - 1'b1;
    assign prod_pq  = p_reg * q_reg;
    assign prod_tot = pm1 * qm1;

    // New coefficient of the inverse: (c0 mod phi + phi - sub) mod phi, where
    // both terms are already below phi, so a single subtraction suffices.
    always_comb
    begin
        t_sum = {1'b0, div_rsp.remainder} + {1'b0, tot_reg} - {1'b0, sub_reg};
        if (t_sum >= {1'b0, tot_reg})
            t_val = MOD_WIDTH'(t_sum - {1'b0, tot_reg});
        else
            t_val = t_sum[MOD_WIDTH-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        key_ready_next = key_ready_reg;
        out_valid_next = out_valid_reg;
        cand_next      = cand_reg;
        mod_next       = mod_reg;
        tot_next       = tot_reg;
        e_next         = e_reg;
        d_next         = d_reg;
        cmd_next       = cmd_reg;
        blk_next       = blk_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        x_next         = x_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        sub_next       = sub_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        ex_next        = ex_reg;
        res_next       = res_reg;
        fit_next       = fit_reg;
        div_req        = '0;
        mul_req        = '0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    blk_next   = s_tdata;
                    state_next = key_ready_reg ? S_EXP_INIT : S_KEY_MUL;
                end
            end
            S_KEY_MUL:
            begin
                mod_next   = prod_pq[MOD_WIDTH-1:0];
                tot_next   = prod_tot[MOD_WIDTH-1:0];
                state_next = S_KEY_CHK;
            end
            S_KEY_CHK:
            begin
                e_next = MOD_WIDTH'(1);
                d_next = MOD_WIDTH'(1);
                if (tot_reg == '0)
                begin
                    key_ready_next = 1'b1;
                    state_next     = S_EXP_INIT;
                end
                else
                begin
                    cand_next  = 9'(E_FIRST);
                    state_next = S_GCD_LOAD;
                end
            end
            S_GCD_LOAD:
            begin
                ga_next    = MOD_WIDTH'(cand_reg);
                gb_next    = tot_reg;
                state_next = S_GCD_TEST;
            end
            S_GCD_TEST:
            begin
                if (gb_reg != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = ga_reg;
                    div_req.divisor  = gb_reg;
                    state_next       = S_GCD_WT;
                end
                else if (ga_reg == MOD_WIDTH'(1))
                begin
                    // Coprime candidate found: start the extended Euclid.
                    e_next           = MOD_WIDTH'(cand_reg);
                    c0_next          = '0;
                    c1_next          = MOD_WIDTH'(1);
                    x_next           = MOD_WIDTH'(cand_reg);
                    div_req.start    = 1'b1;
                    div_req.dividend = tot_reg;
                    div_req.divisor  = MOD_WIDTH'(cand_reg);
                    state_next       = S_INV_DIV;
                end
                else if (cand_reg == 9'(E_LAST))
                begin
                    key_ready_next = 1'b1;
                    state_next     = S_EXP_INIT;
                end
                else
                begin
                    cand_next  = cand_reg + 9'(E_STEP);
                    state_next = S_GCD_LOAD;
                end
            end
            S_GCD_WT:
            begin
                if (div_rsp.done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = div_rsp.remainder;
                    state_next = S_GCD_TEST;
                end
            end
            S_INV_DIV:
            begin
                if (div_rsp.done)
                begin
                    quo_next   = div_rsp.quotient;
                    rem_next   = div_rsp.remainder;
                    state_next = S_INV_TEST;
                end
            end
            S_INV_TEST:
            begin
                if (rem_reg == '0)
                begin
                    d_next         = c1_reg;
                    key_ready_next = 1'b1;
                    state_next     = S_EXP_INIT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = quo_reg;
                    div_req.divisor  = tot_reg;
                    state_next       = S_INV_QM;
                end
            end
            S_INV_QM:
            begin
                if (div_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = div_rsp.remainder;
                    mul_req.b     = c1_reg;
                    mul_req.m     = tot_reg;
                    state_next    = S_INV_MUL;
                end
            end
            S_INV_MUL:
            begin
                if (mul_rsp.done)
                begin
                    sub_next         = mul_rsp.product;
                    div_req.start    = 1'b1;
                    div_req.dividend = c0_reg;
                    div_req.divisor  = tot_reg;
                    state_next       = S_INV_C0;
                end
            end
            S_INV_C0:
            begin
                if (div_rsp.done)
                begin
                    c0_next          = c1_reg;
                    c1_next          = t_val;
                    x_next           = rem_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = x_reg;
                    div_req.divisor  = rem_reg;
                    state_next       = S_INV_DIV;
                end
            end
            S_EXP_INIT:
            begin
                if (mod_reg == '0)
                begin
                    acc_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    ex_next          = cmd_reg ? d_reg : e_reg;
                    acc_next         = (mod_reg == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                    div_req.start    = 1'b1;
                    div_req.dividend = MOD_WIDTH'(blk_reg);
                    div_req.divisor  = mod_reg;
                    state_next       = S_EXP_BASE;
                end
            end
            S_EXP_BASE:
            begin
                if (div_rsp.done)
                begin
                    sq_next    = div_rsp.remainder;
                    state_next = S_EXP_STEP;
                end
            end
            S_EXP_STEP:
            begin
                if (ex_reg == '0)
                    state_next = S_OUT;
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = sq_reg;
                    mul_req.b     = ex_reg[0] ? acc_reg : sq_reg;
                    mul_req.m     = mod_reg;
                    state_next    = ex_reg[0] ? S_EXP_MA : S_EXP_MS;
                end
            end
            S_EXP_MA:
            begin
                if (mul_rsp.done)
                begin
                    acc_next      = mul_rsp.product;
                    mul_req.start = 1'b1;
                    mul_req.a     = sq_reg;
                    mul_req.b     = sq_reg;
                    mul_req.m     = mod_reg;
                    state_next    = S_EXP_MS;
                end
            end
            S_EXP_MS:
            begin
                if (mul_rsp.done)
                begin
                    sq_next    = mul_rsp.product;
                    ex_next    = {1'b0, ex_reg[MOD_WIDTH-1:1]};
                    state_next = S_EXP_STEP;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    res_next       = acc_reg;
                    fit_next       = acc_reg < MOD_WIDTH'(BYTE_LIMIT);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A register write always invalidates the derived key.
        if (cfg_wr)
        begin
            key_ready_next = 1'b0;
            unique case (paddr[2])
                REG_PRIME_P: p_next = pwdata[PRIME_WIDTH-1:0];
                REG_PRIME_Q: q_next = pwdata[PRIME_WIDTH-1:0];
                default:     p_next = p_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_reg         <= PRIME_WIDTH'(251);
            q_reg         <= PRIME_WIDTH'(257);
            key_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mod_reg       <= '0;
            tot_reg       <= '0;
            e_reg         <= '0;
            d_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            q_reg         <= q_next;
            key_ready_reg <= key_ready_next;
            out_valid_reg <= out_valid_next;
            mod_reg       <= mod_next;
            tot_reg       <= tot_next;
            e_reg         <= e_next;
            d_reg         <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        cmd_reg  <= cmd_next;
        blk_reg  <= blk_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        x_reg    <= x_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        sub_reg  <= sub_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        ex_reg   <= ex_next;
        res_reg  <= res_next;
        fit_reg  <= fit_next;
    end

`ifndef SYNTHESIS
    // A derived public exponent is always odd (1 when no candidate was coprime).
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_ready_reg) |-> e_reg[0])
        else $error("public exponent derived even");

    // The exponentiation operands stay reduced below the modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXP_STEP) |-> (acc_reg < mod_reg) && (sq_reg < mod_reg))
        else $error("exponentiation operand not reduced");

    // Any register write leaves the key to be derived again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> !key_ready_reg)
        else $error("key still marked ready after register write");

    // The result register is only loaded when the output side can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_tready) |=> $stable(res_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* src/rkd_divider.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rkd_divider
    import rkd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            quo_reg, quo_next;
    word_t            rem_reg, rem_next;
    word_t            dvs_reg, dvs_next;
    logic [MOD_WIDTH:0] trial;
    logic [MOD_WIDTH:0] diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[MOD_WIDTH-1]};
        ge        = trial >= {1'b0, dvs_reg};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];
            quo_next = {quo_reg[MOD_WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MOD_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

/* src/rkd_modmul.sv */
`default_nettype none

// Interleaved modular multiplier: a*b mod m with a below m, b taken MSB first.
// Each bit takes a doubling step and then an add step, each followed by one
// conditional subtraction of m.
module rkd_modmul
    import rkd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            acc_reg, acc_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    word_t            m_reg, m_next;
    logic [MOD_WIDTH:0] x;
    logic [MOD_WIDTH:0] red;

    always_comb
    begin
        if (!phase_reg)
            x = {acc_reg, 1'b0};
        else
            x = {1'b0, acc_reg} + (b_reg[MOD_WIDTH-1] ? {1'b0, a_reg} : '0);
        red        = x - {1'b0, m_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            acc_next   = '0;
            a_next     = req.a;
            b_next     = req.b;
            m_next     = req.m;
        end
        else if (busy_reg)
        begin
            acc_next   = (x >= {1'b0, m_reg}) ? red[MOD_WIDTH-1:0] : x[MOD_WIDTH-1:0];
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                b_next   = {b_reg[MOD_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MOD_WIDTH - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking testbench for the textbook RSA unit. Primes are written over the
// APB port, blocks are streamed in, and every result is compared against a
// behavioural predictor that derives the same key from the same primes.
module tb_top
    import rkd_pkg::*;
;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;
    localparam logic [APB_AW-1:0] ADDR_PRIME_P = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_PRIME_Q = 3'd4;
    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [31:0] value;
        logic        fits;
    } rsa_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // block_value[15:0]
    logic              s_tuser;   // cmd[0]
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // result_value[31:0]
    logic              m_tuser;   // fits_one_byte[0]
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor copy of the configuration and the derived key.
    logic [15:0] key_p;
    logic [15:0] key_q;
    logic        key_valid;
    logic [63:0] key_n;
    logic [63:0] key_phi;
    logic [63:0] key_e;
    logic [63:0] key_d;

    rsa_result_t pending_results[$];
    int          error_count;
    int          blocks_sent;
    int          results_seen;
    int          key_changes;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    rsa_key_derive_and_modexp_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Euclid on wide words, used for the public exponent search.
    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = b;
            b = a % b;
            a = t;
        end
        return a;
    endfunction

    // Extended Euclid with coefficients kept in 0..m-1 at every step.
    function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] m);
        logic [63:0] c_old;
        logic [63:0] c_cur;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] sub;
        logic [63:0] t;
        c_old = 0;
        c_cur = 1;
        x = a;
        y = m;
        quo = y / x;
        rem = y % x;
        while (rem > 0)
        begin
            sub = ((quo % m) * c_cur) % m;
            t = (c_old % m + m - sub) % m;
            c_old = c_cur;
            c_cur = t;
            y = x;
            x = rem;
            quo = y / x;
            rem = y % x;
        end
        return c_cur;
    endfunction

    // Derives modulus, totient and both exponents from the current primes.
    task automatic derive_rsa_key();
        logic [63:0] pm1;
        logic [63:0] qm1;
        logic [63:0] cand;
        pm1 = (key_p == 0) ? 64'd0 : 64'(key_p) - 64'd1;
        qm1 = (key_q == 0) ? 64'd0 : 64'(key_q) - 64'd1;
        key_n = (64'(key_p) * 64'(key_q)) & 64'hFFFF_FFFF;
        key_phi = (pm1 * qm1) & 64'hFFFF_FFFF;
        key_e = 1;
        key_d = 1;
        if (key_phi != 0)
        begin
            for (cand = 64'(E_FIRST); cand <= 64'(E_LAST); cand += 64'(E_STEP))
            begin
                if (gcd64(cand, key_phi) == 1)
                begin
                    key_e = cand;
                    key_d = mod_inverse(cand, key_phi) & 64'hFFFF_FFFF;
                    break;
                end
            end
        end
        key_valid = 1'b1;
    endtask

    // Right-to-left square-and-multiply; all operands stay below 2^32.
    function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] ex,
                                              logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        if (m == 0)
            return 0;
        acc = 1 % m;
        sq = base % m;
        while (ex > 0)
        begin
            if (ex[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    task automatic predict_rsa_result(logic cmd, logic [15:0] blk);
        rsa_result_t r;
        logic [63:0] v;
        if (!key_valid)
            derive_rsa_key();
        v = power_mod(64'(blk), (cmd == CMD_DECRYPT) ? key_d : key_e, key_n);
        r.value = v[31:0];
        r.fits = (v < 64'(BYTE_LIMIT));
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got,
                 want);
        error_count++;
    endtask

    // Register writes: setup phase, then access phase; pready is always high.
    task automatic write_prime(logic [APB_AW-1:0] addr, logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PRIME_P)
            key_p = value;
        else
            key_q = value;
        key_valid = 1'b0;
    endtask

    // Waits until every expected result has come back, then rewrites the primes.
    task automatic load_primes(logic [15:0] p, logic [15:0] q);
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        write_prime(ADDR_PRIME_P, p);
        write_prime(ADDR_PRIME_Q, q);
        key_changes++;
    endtask

    // Sends one block; the expectation is queued at the accepting edge.
    task automatic send_block(logic cmd, logic [15:0] blk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= cmd;
        #1;
        while (!s_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        predict_rsa_result(cmd, blk);
        blocks_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Receiver back-pressure follows the current idle percentage.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Result checker: each transaction is compared against the oldest expectation.
    always @(posedge clk)
    begin
        rsa_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch("result_value", m_tdata, want.value);
                if (m_tuser !== want.fits)
                    report_mismatch("fits_one_byte", 32'(m_tuser), 32'(want.fits));
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either stream ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // The reset primes 251 and 257, with extreme blocks in both directions.
    task automatic test_reset_key();
        send_block(CMD_ENCRYPT, 16'h0000);
        send_block(CMD_DECRYPT, 16'h0000);
        send_block(CMD_ENCRYPT, 16'h0001);
        send_block(CMD_DECRYPT, 16'hFFFF);
        send_block(CMD_ENCRYPT, 16'hFFFF);
        send_block(CMD_ENCRYPT, 16'h00FF);
        send_block(CMD_DECRYPT, 16'hAAAA);
        send_block(CMD_ENCRYPT, 16'h5555);
        end_burst();
    endtask

    // Degenerate factors: zero modulus, totient zero, modulus one, exponent zero,
    // and the largest values and the largest primes the register accepts.
    task automatic test_degenerate_primes();
        load_primes(16'd0, 16'd257);
        send_block(CMD_ENCRYPT, 16'h1234);
        send_block(CMD_DECRYPT, 16'hFFFF);
        end_burst();
        load_primes(16'd1, 16'd65521);
        send_block(CMD_ENCRYPT, 16'hFFFF);
        send_block(CMD_DECRYPT, 16'h0002);
        end_burst();
        load_primes(16'd1, 16'd1);
        send_block(CMD_ENCRYPT, 16'h0005);
        send_block(CMD_DECRYPT, 16'h0000);
        end_burst();
        load_primes(16'd2, 16'd2);
        send_block(CMD_DECRYPT, 16'h0003);
        send_block(CMD_ENCRYPT, 16'h0003);
        end_burst();
        load_primes(16'd65535, 16'd65535);
        send_block(CMD_ENCRYPT, 16'hFFFE);
        send_block(CMD_DECRYPT, 16'h8001);
        end_burst();
        load_primes(16'd65521, 16'd65519);
        send_block(CMD_ENCRYPT, 16'h7FFF);
        send_block(CMD_DECRYPT, 16'h7FFF);
        end_burst();
    endtask

    // Random keys and blocks in three handshake phases; mostly real primes so
    // that proper keys are derived, with an occasional arbitrary value.
    task automatic test_random_traffic();
        logic [15:0] primes[12] = '{16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd251,
                                    16'd257, 16'd1009, 16'd4093, 16'd32749,
                                    16'd65519, 16'd65521};
        logic [15:0] p;
        logic [15:0] q;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 87 : 0;
            recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 37 : 0;
            for (int k = 0; k < 5; k++)
            begin
                p = ($urandom_range(9) == 0) ? 16'($urandom) :
                    primes[$urandom_range(11)];
                q = ($urandom_range(9) == 0) ? 16'($urandom) :
                    primes[$urandom_range(11)];
                load_primes(p, q);
                for (int i = 0; i < 8; i++)
                    send_block(1'($urandom), 16'($urandom));
                end_burst();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        key_p = 16'd251;
        key_q = 16'd257;
        key_valid = 1'b0;
        error_count = 0;
        blocks_sent = 0;
        results_seen = 0;
        key_changes = 0;
        quiet_cycles = 0;
        send_idle_pct = 37;
        recv_idle_pct = 87;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_key();
        test_degenerate_primes();
        test_random_traffic();

        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        $display("Sent %0d blocks under %0d prime settings; %0d results checked.",
                 blocks_sent, key_changes, results_seen);
        $display("Covered degenerate factors, both commands and three handshake phases.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
